// File: rtl/core/dss_pkg.sv
// ============================================================================
// dss_pkg: shared definitions for the dual stack shared memory block
// Sizes, action and status codes, and controller/datapath interface types.
// ============================================================================
package dss_pkg;

    localparam int MAX_ENTRIES  = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int ADDR_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS     = 11;
    localparam int CAP_BITS     = 11;
    localparam int ACTION_BITS  = 3;
    localparam int STATUS_BITS  = 2;
    localparam int IN_BITS      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = VALUE_BITS + STATUS_BITS + 2 * CNT_BITS;
    localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PUSH_ONE = 3'd0,
        ACT_PUSH_TWO = 3'd1,
        ACT_POP_ONE  = 3'd2,
        ACT_POP_TWO  = 3'd3,
        ACT_PEEK_ONE = 3'd4,
        ACT_PEEK_TWO = 3'd5
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_dp_cmd;

endpackage

// File: rtl/core/dss_ram.sv
// ============================================================================
// dss_ram: generic single write port, single read port RAM
// Read data is registered and holds until the next read.
// ============================================================================
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/dss_ctrl.sv
// ============================================================================
// dss_ctrl: sequencing controller
// Steps each item through capture, execute and result load; owns result valid.
// ============================================================================
module dss_ctrl
    import dss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/dss_datapath.sv
// ============================================================================
// dss_datapath: stack counters, capacity register, shared memory and result
// Decides push/pop/peek outcome, addresses the shared RAM, forms the result.
// ============================================================================
module dss_datapath
    import dss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [ACTION_BITS-1:0] i_action,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  logic                   i_cfg_wr_en,
    input  logic [CAP_BITS-1:0]    i_cfg_wr_data,
    output logic [VALUE_BITS-1:0]  o_read_value,
    output t_status                o_status,
    output logic [CNT_BITS-1:0]    o_depth_one,
    output logic [CNT_BITS-1:0]    o_depth_two
);

    logic [ACTION_BITS-1:0] r_action;
    logic [VALUE_BITS-1:0]  r_value;
    logic [CAP_BITS-1:0]    r_cap, n_cap;
    logic [CNT_BITS-1:0]    r_cnt_one, n_cnt_one;
    logic [CNT_BITS-1:0]    r_cnt_two, n_cnt_two;
    t_status                r_status, n_status;
    logic                   r_rd_ok, n_rd_ok;
    logic [VALUE_BITS-1:0]  r_read_value;
    t_status                r_out_status;
    logic [CNT_BITS-1:0]    r_out_one;
    logic [CNT_BITS-1:0]    r_out_two;

    logic [CNT_BITS:0]      w_sum;
    logic                   w_full;
    logic [CNT_BITS-1:0]    w_idx;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [VALUE_BITS-1:0]  w_rd_data;

    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_cap = CAP_BITS'(1);
        end else if (i_cfg_wr_data > CAP_BITS'(MAX_ENTRIES)) begin
            n_cap = CAP_BITS'(MAX_ENTRIES);
        end else begin
            n_cap = i_cfg_wr_data;
        end
    end

    assign w_sum  = {1'b0, r_cnt_one} + {1'b0, r_cnt_two};
    assign w_full = w_sum >= {1'b0, r_cap};

    always_comb begin
        n_cnt_one = r_cnt_one;
        n_cnt_two = r_cnt_two;
        n_status  = ST_OK;
        n_rd_ok   = 1'b0;
        w_idx     = '0;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        case (t_action'(r_action))
            ACT_PUSH_ONE: begin
                if (w_full) begin
                    n_status = ST_OVER;
                end else begin
                    w_idx     = r_cnt_one;
                    w_wr_en   = 1'b1;
                    n_cnt_one = r_cnt_one + CNT_BITS'(1);
                end
            end
            ACT_PUSH_TWO: begin
                if (w_full) begin
                    n_status = ST_OVER;
                end else begin
                    n_cnt_two = r_cnt_two + CNT_BITS'(1);
                    w_idx     = r_cap - n_cnt_two;
                    w_wr_en   = 1'b1;
                end
            end
            ACT_POP_ONE, ACT_PEEK_ONE: begin
                if (r_cnt_one == '0) begin
                    n_status = ST_UNDER;
                end else begin
                    w_idx   = r_cnt_one - CNT_BITS'(1);
                    w_rd_en = 1'b1;
                    n_rd_ok = 1'b1;
                    if (t_action'(r_action) == ACT_POP_ONE) begin
                        n_cnt_one = r_cnt_one - CNT_BITS'(1);
                    end
                end
            end
            ACT_POP_TWO, ACT_PEEK_TWO: begin
                if (r_cnt_two == '0) begin
                    n_status = ST_UNDER;
                end else begin
                    w_idx   = r_cap - r_cnt_two;
                    w_rd_en = 1'b1;
                    n_rd_ok = 1'b1;
                    if (t_action'(r_action) == ACT_POP_TWO) begin
                        n_cnt_two = r_cnt_two - CNT_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_BITS'(MAX_ENTRIES);
            r_cnt_one <= '0;
            r_cnt_two <= '0;
        end else if (i_cfg_wr_en) begin
            r_cap     <= n_cap;
            r_cnt_one <= '0;
            r_cnt_two <= '0;
        end else if (i_cmd.exec) begin
            r_cnt_one <= n_cnt_one;
            r_cnt_two <= n_cnt_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
        if (i_cmd.emit) begin
            r_read_value <= r_rd_ok ? w_rd_data : '0;
            r_out_status <= r_status;
            r_out_one    <= r_cnt_one;
            r_out_two    <= r_cnt_two;
        end
    end

    dss_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.exec && w_wr_en),
        .i_wr_addr (w_idx[ADDR_BITS-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (i_cmd.exec && w_rd_en),
        .i_rd_addr (w_idx[ADDR_BITS-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign o_read_value = r_read_value;
    assign o_status     = r_out_status;
    assign o_depth_one  = r_out_one;
    assign o_depth_two  = r_out_two;

endmodule

// File: rtl/core/dual_stack_shared_memory.sv
// ============================================================================
// dual_stack_shared_memory: two LIFO stacks in one shared RAM
// Stack one grows up from entry 0, stack two down from the capacity top.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata push_value, tuser action
//   m_axis    out  tvalid/tready        tdata read_value/status/depths
//   cfg       in   wr_en                wr_data capacity_in_use
//
// Each item passes through capture, RAM access and result load, in that order.
// The RAM read is registered, so the result load follows the RAM access step.
// A result waits in the output register; the next item is captured meanwhile
// and its result load holds until the output register is free.
// Reset is synchronous; no clearing pass, the RAM content is never reset.
// ============================================================================
module dual_stack_shared_memory
    import dss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [31:0] push_value
    input  logic [IN_BITS-1:0]     i_s_axis_tdata,
    // [2:0] action
    input  logic [ACTION_BITS-1:0] i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] read_value, [33:32] status, [44:34] depth_one, [55:45] depth_two
    output logic [OUT_BITS-1:0]    o_m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CAP_BITS-1:0]    i_cfg_wr_data
);

    t_dp_cmd               w_cmd;
    logic [VALUE_BITS-1:0] w_read_value;
    t_status               w_status;
    logic [CNT_BITS-1:0]   w_depth_one;
    logic [CNT_BITS-1:0]   w_depth_two;

    dss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    dss_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (i_s_axis_tuser),
        .i_value       (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_read_value  (w_read_value),
        .o_status      (w_status),
        .o_depth_one   (w_depth_one),
        .o_depth_two   (w_depth_two)
    );

    assign o_m_axis_tdata = OUT_BITS'({w_depth_two, w_depth_one, w_status, w_read_value});

endmodule
